// File: design/qdsp_pkg.sv
// Shared types and constants for the QPSK derotate, slice and pack block.
// No dependencies; imported by qdsp_slicer and qpsk_derotate_slice_pack.
package qdsp_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int ROT_W         = PROD_W + 1;
    localparam int SYM_W         = 2;
    localparam int SYMS_PER_WORD = 16;
    localparam int WORD_W        = SYM_W * SYMS_PER_WORD;
    localparam int POS_W         = $clog2(SYMS_PER_WORD);
    localparam int CNT_W         = 5;
    localparam int SHIFT_W       = POS_W + 1;

    localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd0;

    typedef enum logic [0:0] {
        CFG_COS = 1'b0,
        CFG_SIN = 1'b1
    } cfg_reg_t;

endpackage

// File: design/qdsp_slicer.sv
// Phase derotation and quadrant hard decision for one complex sample.
// Depends on qdsp_pkg for widths.
module qdsp_slicer
    import qdsp_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample_i,
    input  logic signed [SAMPLE_W-1:0] sample_q,
    input  logic signed [COEF_W-1:0]   cos_c,
    input  logic signed [COEF_W-1:0]   sin_c,
    output logic        [SYM_W-1:0]    sym
);

    logic signed [PROD_W-1:0] ic_prod;
    logic signed [PROD_W-1:0] qs_prod;
    logic signed [PROD_W-1:0] qc_prod;
    logic signed [PROD_W-1:0] is_prod;
    logic signed [ROT_W-1:0]  rot_i;
    logic signed [ROT_W-1:0]  rot_q;

    assign ic_prod = sample_i * cos_c;
    assign qs_prod = sample_q * sin_c;
    assign qc_prod = sample_q * cos_c;
    assign is_prod = sample_i * sin_c;

    // full width, so the sign is exact
    assign rot_i = ROT_W'(ic_prod) + ROT_W'(qs_prod);
    assign rot_q = ROT_W'(qc_prod) - ROT_W'(is_prod);

    always_comb
    begin
        if ((rot_i != '0) && (rot_q != '0))
        begin
            sym = {rot_i[ROT_W-1], rot_q[ROT_W-1]};
        end
        else
        begin
            sym = '0;
        end
    end

endmodule

// File: design/qpsk_derotate_slice_pack.sv
// Top level: QPSK derotation, hard decision and 32-bit word packing.
// Depends on qdsp_pkg and qdsp_slicer.
//
// One sample is accepted per clock cycle unless a finished word stalls.
// The sample is captured in an input register, then the four 16x16
// products, the 33-bit sums and the sign slice run combinationally into
// the packing accumulator and the output word register. Sixteen symbols
// fill a word, symbol k in bits 2k+1:2k; a sample marked frame_end closes
// the word early with last set, and unused positions read as zero. A
// symbol whose rotated I or Q is exactly zero is sliced to 00. While a
// word waits on out_ready one more sample can still be taken into the
// input register. Coefficients (CFG_COS cosine, CFG_SIN sine, both Q1.14)
// must be written via the cfg port only while the block is idle, unchecked.
module qpsk_derotate_slice_pack
    import qdsp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_i,
    input  logic signed [SAMPLE_W-1:0] sample_q,
    input  logic                       frame_end,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WORD_W-1:0]          packed_word,
    output logic [CNT_W-1:0]           symbol_count,
    output logic                       last
);

    logic signed [COEF_W-1:0]   cos_reg;
    logic signed [COEF_W-1:0]   sin_reg;

    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_i_reg;
    logic signed [SAMPLE_W-1:0] a_q_reg;
    logic                       a_fe_reg;

    logic [WORD_W-1:0]          acc_reg;
    logic [POS_W-1:0]           pos_reg;

    logic                       out_valid_reg;
    logic [WORD_W-1:0]          word_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       last_reg;

    logic                       advance;
    logic                       fire;
    logic [SYM_W-1:0]           sym;
    logic [SHIFT_W-1:0]         shamt;
    logic [CNT_W-1:0]           count_next;
    logic [WORD_W-1:0]          word_next;
    logic                       emit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= COS_RESET;
            sin_reg <= SIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_COS: cos_reg <= cfg_data;
                CFG_SIN: sin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stall only when a finished word is still waiting
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || advance;
    assign fire     = a_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_i_reg  <= sample_i;
            a_q_reg  <= sample_q;
            a_fe_reg <= frame_end;
        end
    end

    qdsp_slicer u_slicer (
        .sample_i (a_i_reg),
        .sample_q (a_q_reg),
        .cos_c    (cos_reg),
        .sin_c    (sin_reg),
        .sym      (sym)
    );

    assign shamt      = {pos_reg, 1'b0};
    assign count_next = CNT_W'(pos_reg) + CNT_W'(1);
    assign word_next  = acc_reg | (WORD_W'(sym) << shamt);
    assign emit       = (count_next == CNT_W'(SYMS_PER_WORD)) || a_fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
        end
        else if (fire)
        begin
            if (emit)
            begin
                acc_reg <= '0;
                pos_reg <= '0;
            end
            else
            begin
                acc_reg <= word_next;
                pos_reg <= count_next[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
            last_reg  <= a_fe_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packed_word  = word_reg;
    assign symbol_count = count_reg;
    assign last         = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol_count != '0) && (symbol_count <= CNT_W'(SYMS_PER_WORD)))
        else $error("symbol_count out of range");

    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (symbol_count == CNT_W'(SYMS_PER_WORD)))
        else $error("short word without frame end");

    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> (pos_reg == '0) && (acc_reg == '0))
        else $error("accumulator not cleared after word");

endmodule

// File: bench/qpsk_derotate_slice_pack_tb.sv
// Testbench for qpsk_derotate_slice_pack: directed sample table, then random phases.
// A local predictor derotates, slices and packs each accepted sample; every word is checked.
// Depends on qdsp_pkg and the qpsk_derotate_slice_pack RTL.
module qpsk_derotate_slice_pack_tb;
    import qdsp_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              last;
    } word_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic                       fe;
        logic                       typed;
        logic [WORD_W-1:0]          exp_word;
        logic [CNT_W-1:0]           exp_count;
        logic                       exp_last;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [0:0]                 cfg_index = CFG_COS;
    logic [COEF_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_i = '0;
    logic signed [SAMPLE_W-1:0] sample_q = '0;
    logic                       frame_end = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [WORD_W-1:0]          packed_word;
    logic [CNT_W-1:0]           symbol_count;
    logic                       last;

    // predictor state
    logic signed [COEF_W-1:0]   cos_q14 = COS_RESET;
    logic signed [COEF_W-1:0]   sin_q14 = SIN_RESET;
    logic [WORD_W-1:0]          pack_acc = '0;
    int                         pack_pos = 0;
    word_beat_t                 pending_words [$];
    word_beat_t                 want_beat;

    // typed expectation travelling with the current input beat
    logic                       row_typed = 1'b0;
    word_beat_t                 row_beat = '0;

    int                         mismatch_count = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;

    stim_row_t                  dir_rows [0:21];
    int                         cos_set [0:6] = '{16384, 0, -16384, 0, 11585, -16384, 16384};
    int                         sin_set [0:6] = '{0, 16384, 0, -16384, 11585, 16384, -16384};

    qpsk_derotate_slice_pack u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packed_word  (packed_word),
        .symbol_count (symbol_count),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [1:0] slice_quadrant(input logic signed [SAMPLE_W-1:0] si,
                                                  input logic signed [SAMPLE_W-1:0] sq);
        longint rot_i;
        longint rot_q;
        rot_i = longint'(si) * longint'(cos_q14) + longint'(sq) * longint'(sin_q14);
        rot_q = longint'(sq) * longint'(cos_q14) - longint'(si) * longint'(sin_q14);
        if (rot_i == 0 || rot_q == 0)
            return 2'b00;
        return {rot_i < 0, rot_q < 0};
    endfunction

    task automatic pack_symbol(input logic signed [SAMPLE_W-1:0] si,
                               input logic signed [SAMPLE_W-1:0] sq,
                               input logic fe, input logic typed, input word_beat_t typed_beat);
        word_beat_t done;
        if (pack_pos < SYMS_PER_WORD)
            pack_acc[2*pack_pos +: 2] = slice_quadrant(si, sq);
        pack_pos++;
        if (pack_pos >= SYMS_PER_WORD || fe)
        begin
            done.word  = pack_acc;
            done.count = pack_pos[CNT_W-1:0];
            done.last  = fe;
            pending_words.push_back(typed ? typed_beat : done);
            pack_acc = '0;
            pack_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // beats on both channels are seen here, pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pack_symbol(sample_i, sample_q, frame_end, row_typed, row_beat);
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("word with none pending", packed_word, '0);
                else
                begin
                    want_beat = pending_words.pop_front();
                    if (packed_word !== want_beat.word)
                        report_mismatch("packed_word", packed_word, want_beat.word);
                    if (symbol_count !== want_beat.count)
                        report_mismatch("symbol_count", symbol_count, want_beat.count);
                    if (last !== want_beat.last)
                        report_mismatch("last", last, want_beat.last);
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                               input logic signed [SAMPLE_W-1:0] sq,
                               input logic fe, input logic typed, input word_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_i  <= si;
        sample_q  <= sq;
        frame_end <= fe;
        row_typed <= typed;
        row_beat  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // wait out every pending word, then the pipeline latency
    task automatic drain_words();
        in_valid  <= 1'b0;
        row_typed <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_coeffs(input logic [COEF_W-1:0] c, input logic [COEF_W-1:0] s);
        cfg_reg_t idx;
        for (int n = 0; n < 2; n++)
        begin
            idx = (n == 0) ? CFG_COS : CFG_SIN;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == CFG_COS) ? c : s;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == CFG_COS)
                cos_q14 = c;
            else
                sin_q14 = s;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] edge_sample();
        case ($urandom_range(4))
            0: return -16'sd32767 - 16'sd1;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // biased so that exact zeros after derotation turn up under any coefficients
    task automatic random_pair(output logic signed [SAMPLE_W-1:0] si,
                               output logic signed [SAMPLE_W-1:0] sq);
        int k;
        k = $urandom_range(1) ? 1 : -1;
        case ($urandom_range(9))
            0:
            begin
                si = SAMPLE_W'(k * sin_q14);
                sq = SAMPLE_W'(-k * cos_q14);
            end
            1:
            begin
                si = SAMPLE_W'(k * cos_q14);
                sq = SAMPLE_W'(k * sin_q14);
            end
            2:
            begin
                si = edge_sample();
                sq = edge_sample();
            end
            default:
            begin
                si = SAMPLE_W'($urandom);
                sq = SAMPLE_W'($urandom);
            end
        endcase
    endtask

    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        word_beat_t                 beat;
        logic [COEF_W-1:0]          c;
        logic [COEF_W-1:0]          s;

        // single-symbol frames at reset coefficients, then one full word closed by frame_end
        dir_rows = '{
            '{-32768, -32768, 1'b1, 1'b1, 32'h3, 5'd1, 1'b1},
            '{ 32767,  32767, 1'b1, 1'b1, 32'h0, 5'd1, 1'b1},
            '{ 32767, -32768, 1'b1, 1'b1, 32'h1, 5'd1, 1'b1},
            '{-32768,  32767, 1'b1, 1'b1, 32'h2, 5'd1, 1'b1},
            '{     0,     -5, 1'b1, 1'b1, 32'h0, 5'd1, 1'b1},
            '{    -7,      0, 1'b1, 1'b1, 32'h0, 5'd1, 1'b1},
            '{     1,      1, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{     1,     -1, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{    -1,      1, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{    -1,     -1, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{ 32767,  32767, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{ 32767, -32768, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{-32768,  32767, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{-32768, -32768, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{   300,  12000, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{ 25000,     -9, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{ -4096,      2, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{   -17, -30000, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{     5,      5, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{  8191,  -8192, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{    -1,  32767, 1'b0, 1'b0, 32'h0, 5'd0, 1'b0},
            '{-32768,     -1, 1'b1, 1'b1, 32'hE4E4E4E4, 5'd16, 1'b1}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        foreach (dir_rows[r])
        begin
            beat = '{dir_rows[r].exp_word, dir_rows[r].exp_count, dir_rows[r].exp_last};
            send_sample(dir_rows[r].si, dir_rows[r].sq, dir_rows[r].fe, dir_rows[r].typed, beat);
        end

        for (int p = 0; p < 8; p++)
        begin
            drain_words();
            send_idle_pct  = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 22 : 0;
            recv_stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 22 : 0;
            if (p < 7)
            begin
                c = COEF_W'(cos_set[p]);
                s = COEF_W'(sin_set[p]);
            end
            else
            begin
                c = COEF_W'(int'($urandom_range(32768)) - 16384);
                s = COEF_W'(int'($urandom_range(32768)) - 16384);
            end
            load_coeffs(c, s);
            for (int n = 0; n < 125; n++)
            begin
                random_pair(si, sq);
                send_sample(si, sq, $urandom_range(19) == 0, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
